[sv/sorted_key_table_macros.svh]
// ----------------------------------------------------------------------------
// sorted key table assertion macros
// shared concurrent assertion forms, clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH

// same-cycle implication
`define SKT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SKT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/skt_pkg.sv]
// ----------------------------------------------------------------------------
// skt_pkg
// types, constants and helper functions of the sorted key table
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int KEY_W  = 16;
  localparam int ATTR_W = 16;
  localparam int POS_W  = 5;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic              kind;
    logic [ATTR_W-1:0] attribute;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic occupied;
    logic at_end;
  } cell_ctl_t;

  typedef struct packed {
    logic held;
    logic gt;
    logic eq;
  } cell_flag_t;

  typedef struct packed {
    logic             hit;
    entry_t           entry;
    logic [IDX_W-1:0] pos;
    logic [CNT_W-1:0] ins_pos;
  } pick_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [KEY_W-1:0]  found_key;
    logic              found_kind;
    logic [ATTR_W-1:0] found_attribute;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  entry_total;
  } out_item_t;

  // lowest set bit only
  function automatic logic [DEPTH-1:0] first_one(input logic [DEPTH-1:0] v);
    return v & (~v + 1'b1);
  endfunction

  // one-hot to binary
  function automatic logic [IDX_W-1:0] encode(input logic [DEPTH-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (v[i]) begin
        r = r | IDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage

[sv/skt_if.sv]
// ----------------------------------------------------------------------------
// skt channel interfaces
// request and response channels with valid/ready transfer
// ----------------------------------------------------------------------------
interface skt_req_if import skt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [KEY_W-1:0]  key;
  logic              kind;
  logic [ATTR_W-1:0] attribute;
  logic [IDX_W-1:0]  index;

  modport source(output valid, output op, output key, output kind, output attribute,
                 output index, input ready);
  modport sink(input valid, input op, input key, input kind, input attribute,
               input index, output ready);
endinterface

interface skt_rsp_if import skt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [KEY_W-1:0]  found_key;
  logic              found_kind;
  logic [ATTR_W-1:0] found_attribute;
  logic [POS_W-1:0]  position;
  logic [POS_W-1:0]  entry_total;

  modport source(output valid, output status, output found_key, output found_kind,
                 output found_attribute, output position, output entry_total,
                 input ready);
  modport sink(input valid, input status, input found_key, input found_kind,
               input found_attribute, input position, input entry_total,
               output ready);
endinterface

[sv/skt_cell.sv]
// ----------------------------------------------------------------------------
// skt_cell
// one table slot: compares its key with the request and takes its left
// neighbor's entry or the new entry on insert
// ----------------------------------------------------------------------------
module skt_cell import skt_pkg::*; (
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  entry_t     new_entry,
  input  entry_t     left_entry,
  input  logic       left_gt,
  output entry_t     entry,
  output cell_flag_t flags
);

  logic gt;

  assign gt = ctl.occupied && (entry.key > new_entry.key);

  assign flags.held = ctl.occupied;
  assign flags.gt   = gt;
  assign flags.eq   = ctl.occupied && (entry.key == new_entry.key);

  // left larger: shift up; first larger or first free slot: new entry
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (left_gt) begin
        entry <= left_entry;
      end else if (gt || ctl.at_end) begin
        entry <= new_entry;
      end
    end
  end

endmodule

[sv/skt_pick.sv]
// ----------------------------------------------------------------------------
// skt_pick
// picks the matching or indexed slot and the insert position from the row
// ----------------------------------------------------------------------------
module skt_pick import skt_pkg::*; (
  input  entry_t           entries [DEPTH],
  input  cell_flag_t       flags   [DEPTH],
  input  logic [1:0]       op,
  input  logic [IDX_W-1:0] index,
  input  logic [CNT_W-1:0] count,
  output pick_t            pick
);

  logic [DEPTH-1:0] eq_vec;
  logic [DEPTH-1:0] gt_vec;
  logic [DEPTH-1:0] rd_vec;
  logic [DEPTH-1:0] sel;
  logic [DEPTH-1:0] gt_first;
  entry_t           data;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      eq_vec[i] = flags[i].eq;
      gt_vec[i] = flags[i].gt;
      rd_vec[i] = flags[i].held && (index == IDX_W'(i));
    end
  end

  always_comb begin
    case (op)
      OP_FIND: sel = first_one(eq_vec);
      OP_READ: sel = rd_vec;
      default: sel = '0;
    endcase
  end

  always_comb begin
    data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      data = data | (entries[i] & {$bits(entry_t){sel[i]}});
    end
  end

  assign gt_first = first_one(gt_vec);

  assign pick.hit     = |sel;
  assign pick.entry   = data;
  assign pick.pos     = encode(sel);
  assign pick.ins_pos = (|gt_vec) ? CNT_W'(encode(gt_first)) : count;

endmodule

[sv/sorted_key_table.sv]
// ----------------------------------------------------------------------------
// sorted_key_table
// table of up to DEPTH entries kept in ascending key order
// ----------------------------------------------------------------------------
// Each request (insert, find by key, read at index) is handled at once: the row
// of cells compares every held key against the request key in parallel, the
// insert shifts the larger entries up one cell on the same edge, and the
// answer lands in the response register in the cycle after the transfer.
// A new request is taken whenever the response register is empty or is
// being drained: without receiver stalls, one transfer per cycle.
// ----------------------------------------------------------------------------
`include "sorted_key_table_macros.svh"

module sorted_key_table import skt_pkg::*; (
  input logic     clk,
  input logic     rst,
  skt_req_if.sink   req,
  skt_rsp_if.source rsp
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             rsp_valid;
  out_item_t        res;
  out_item_t        res_next;

  logic       acc;
  logic       full;
  logic       ins_go;
  entry_t     new_entry;
  entry_t     entries [DEPTH];
  cell_flag_t flags   [DEPTH];
  pick_t      pick;

  assign req.ready = !rsp_valid || rsp.ready;
  assign acc       = req.valid && req.ready;
  assign full      = (count == CNT_W'(DEPTH));
  assign ins_go    = acc && (req.op == OP_INSERT) && !full;

  assign new_entry.key       = req.key;
  assign new_entry.kind      = req.kind;
  assign new_entry.attribute = req.attribute;

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t ctl;
    entry_t    left_entry;
    logic      left_gt;

    assign ctl.ins      = ins_go;
    assign ctl.occupied = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign left_entry = new_entry;
      assign left_gt    = 1'b0;
      assign ctl.at_end = (count == CNT_W'(i));
    end else begin : g_body
      assign left_entry = entries[i-1];
      assign left_gt    = flags[i-1].gt;
      assign ctl.at_end = (count == CNT_W'(i));
    end

    skt_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .new_entry  (new_entry),
      .left_entry (left_entry),
      .left_gt    (left_gt),
      .entry      (entries[i]),
      .flags      (flags[i])
    );
  end

  skt_pick u_pick (
    .entries (entries),
    .flags   (flags),
    .op      (req.op),
    .index   (req.index),
    .count   (count),
    .pick    (pick)
  );

  always_comb begin
    count_next           = ins_go ? count + 1'b1 : count;
    res_next.status      = ST_NOT_FOUND;
    res_next.found_key   = '0;
    res_next.found_kind  = 1'b0;
    res_next.found_attribute = '0;
    res_next.position    = POS_W'(count);
    res_next.entry_total = POS_W'(count_next);
    case (req.op)
      OP_INSERT: begin
        if (full) begin
          res_next.status = ST_FULL;
        end else begin
          res_next.status   = ST_OK;
          res_next.position = POS_W'(pick.ins_pos);
        end
      end
      OP_FIND, OP_READ: begin
        if (pick.hit) begin
          res_next.status          = ST_OK;
          res_next.found_key       = pick.entry.key;
          res_next.found_kind      = pick.entry.kind;
          res_next.found_attribute = pick.entry.attribute;
          res_next.position        = POS_W'(pick.pos);
        end
      end
      default: begin
        res_next.status = ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (acc) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res <= res_next;
    end
  end

  assign rsp.valid           = rsp_valid;
  assign rsp.status          = res.status;
  assign rsp.found_key       = res.found_key;
  assign rsp.found_kind      = res.found_kind;
  assign rsp.found_attribute = res.found_attribute;
  assign rsp.position        = res.position;
  assign rsp.entry_total     = res.entry_total;

  `SKT_ASSERT_NOW(a_count_max, 1'b1, count <= CNT_W'(DEPTH), "entry count above depth")
  `SKT_ASSERT_NEXT(a_count_inc, ins_go, count == $past(count) + 1'b1, "insert did not count")
  `SKT_ASSERT_NEXT(a_rsp_after_req, acc, rsp.valid, "no response after request transfer")
  `SKT_ASSERT_NEXT(a_find_key, acc && req.op == OP_FIND && pick.hit,
                   rsp.found_key == $past(req.key), "find returned a different key")

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: sorted key table testbench
// Requests go in and answers come back over valid/ready channels. A local
// model of the sorted table predicts every answer. Phase one replays a table
// of opening requests: the empty table, extreme keys, equal keys, filling to
// full, a refused insert and the unused op code. The random phases then run
// finds of held and unheld keys, reads, refused inserts and the unused op
// code. Sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_top;
  import skt_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int OPENING_ROWS = 25;
  localparam int RANDOM_PER_PHASE = 375;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [1:0]        op;
    logic [KEY_W-1:0]  key;
    logic              kind;
    logic [ATTR_W-1:0] attribute;
    logic [IDX_W-1:0]  index;
    logic              typed;
    out_item_t         want;
  } opening_row_t;

  // rows with typed = 1 carry their answer; the rest use the table model
  localparam opening_row_t OPENING_STEPS [OPENING_ROWS] = '{
    '{OP_FIND, 16'h0000, 1'b0, 16'h0000, 4'h0, 1'b1, '{ST_NOT_FOUND, 16'h0, 1'b0, 16'h0, 5'd0, 5'd0}},
    '{OP_READ, 16'h0000, 1'b0, 16'h0000, 4'h0, 1'b1, '{ST_NOT_FOUND, 16'h0, 1'b0, 16'h0, 5'd0, 5'd0}},
    '{OP_UNUSED, 16'hffff, 1'b1, 16'hffff, 4'hf, 1'b1, '{ST_NOT_FOUND, 16'h0, 1'b0, 16'h0, 5'd0, 5'd0}},
    '{OP_INSERT, 16'hffff, 1'b1, 16'hffff, 4'h0, 1'b1, '{ST_OK, 16'h0, 1'b0, 16'h0, 5'd0, 5'd1}},
    '{OP_INSERT, 16'h0000, 1'b0, 16'h0000, 4'h0, 1'b1, '{ST_OK, 16'h0, 1'b0, 16'h0, 5'd0, 5'd2}},
    '{OP_INSERT, 16'hffff, 1'b0, 16'h1234, 4'h0, 1'b1, '{ST_OK, 16'h0, 1'b0, 16'h0, 5'd2, 5'd3}},
    '{OP_INSERT, 16'h0000, 1'b1, 16'haaaa, 4'h0, 1'b1, '{ST_OK, 16'h0, 1'b0, 16'h0, 5'd1, 5'd4}},
    '{OP_FIND, 16'hffff, 1'b0, 16'h0000, 4'h0, 1'b0, '0},
    '{OP_READ, 16'h0000, 1'b0, 16'h0000, 4'hf, 1'b0, '0},
    '{OP_INSERT, 16'h8000, 1'b1, 16'h5555, 4'h0, 1'b0, '0},
    '{OP_INSERT, 16'h7fff, 1'b0, 16'haaaa, 4'h0, 1'b0, '0},
    '{OP_INSERT, 16'h0001, 1'b1, 16'h0001, 4'h0, 1'b0, '0},
    '{OP_INSERT, 16'hfffe, 1'b0, 16'hfffe, 4'h0, 1'b0, '0},
    '{OP_INSERT, 16'h1234, 1'b1, 16'h8000, 4'h0, 1'b0, '0},
    '{OP_INSERT, 16'h4321, 1'b0, 16'h7fff, 4'h0, 1'b0, '0},
    '{OP_INSERT, 16'h8000, 1'b0, 16'h0f0f, 4'h0, 1'b0, '0},
    '{OP_INSERT, 16'h00ff, 1'b1, 16'hf0f0, 4'h0, 1'b0, '0},
    '{OP_INSERT, 16'hff00, 1'b0, 16'h00ff, 4'h0, 1'b0, '0},
    '{OP_INSERT, 16'h0f0f, 1'b1, 16'hff00, 4'h0, 1'b0, '0},
    '{OP_INSERT, 16'hf0f0, 1'b0, 16'h3c3c, 4'h0, 1'b0, '0},
    '{OP_INSERT, 16'h3c3c, 1'b1, 16'hc3c3, 4'h0, 1'b0, '0},
    '{OP_INSERT, 16'h5a5a, 1'b1, 16'ha5a5, 4'h0, 1'b1, '{ST_FULL, 16'h0, 1'b0, 16'h0, 5'd16, 5'd16}},
    '{OP_READ, 16'h0000, 1'b0, 16'h0000, 4'hf, 1'b0, '0},
    '{OP_FIND, 16'h8000, 1'b0, 16'h0000, 4'h0, 1'b0, '0},
    '{OP_FIND, 16'h0002, 1'b0, 16'h0000, 4'h0, 1'b1, '{ST_NOT_FOUND, 16'h0, 1'b0, 16'h0, 5'd16, 5'd16}}
  };

  logic clk;
  logic rst;

  skt_req_if req_ch ();
  skt_rsp_if rsp_ch ();

  sorted_key_table DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  entry_t    held [DEPTH];
  int        held_count;
  out_item_t expected_answers [$];
  out_item_t oldest;
  int        failures;
  int        idle_pct;
  int        stall_pct;
  int        cycle_count;
  int        n_transfers;
  int        n_placed, n_refused, n_find_hit, n_find_miss, n_read_in, n_read_out, n_unused;

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d answers outstanding", $time, expected_answers.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // table model: applies one request and returns its answer
  function automatic out_item_t apply_request(input logic [1:0] op,
                                              input logic [KEY_W-1:0] key,
                                              input logic kind,
                                              input logic [ATTR_W-1:0] attribute,
                                              input logic [IDX_W-1:0] index);
    out_item_t ans;
    int        slot;
    logic      hit;
    ans = '0;
    ans.status = ST_NOT_FOUND;
    ans.position = POS_W'(held_count);
    case (op)
      OP_INSERT: begin
        if (held_count >= DEPTH) begin
          ans.status = ST_FULL;
          n_refused++;
        end else begin
          slot = held_count;
          for (int i = 0; i < held_count; i++) begin
            if (slot == held_count && held[i].key > key) begin
              slot = i;
            end
          end
          for (int i = held_count; i > slot; i--) begin
            held[i] = held[i-1];
          end
          held[slot] = '{key: key, kind: kind, attribute: attribute};
          held_count++;
          ans.status = ST_OK;
          ans.position = POS_W'(slot);
          n_placed++;
        end
      end
      OP_FIND: begin
        hit = 1'b0;
        for (int i = 0; i < held_count; i++) begin
          if (!hit && held[i].key == key) begin
            hit = 1'b1;
            ans.status = ST_OK;
            ans.found_key = held[i].key;
            ans.found_kind = held[i].kind;
            ans.found_attribute = held[i].attribute;
            ans.position = POS_W'(i);
          end
        end
        if (hit) begin
          n_find_hit++;
        end else begin
          n_find_miss++;
        end
      end
      OP_READ: begin
        if (int'(index) < held_count) begin
          ans.status = ST_OK;
          ans.found_key = held[index].key;
          ans.found_kind = held[index].kind;
          ans.found_attribute = held[index].attribute;
          ans.position = POS_W'(index);
          n_read_in++;
        end else begin
          n_read_out++;
        end
      end
      default: begin
        n_unused++;
      end
    endcase
    ans.entry_total = POS_W'(held_count);
    return ans;
  endfunction

  // drives one request and returns once it has transferred
  task automatic send_request(input logic [1:0] op, input logic [KEY_W-1:0] key,
                              input logic kind, input logic [ATTR_W-1:0] attribute,
                              input logic [IDX_W-1:0] index);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op <= op;
    req_ch.key <= key;
    req_ch.kind <= kind;
    req_ch.attribute <= attribute;
    req_ch.index <= index;
    do begin
      @(posedge clk);
    end while (!req_ch.ready);
    n_transfers++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: answer with nothing expected, status %0h", $time, rsp_ch.status);
        failures++;
      end else begin
        oldest = expected_answers.pop_front();
        compare_field("status", 32'(oldest.status), 32'(rsp_ch.status));
        compare_field("found_key", 32'(oldest.found_key), 32'(rsp_ch.found_key));
        compare_field("found_kind", 32'(oldest.found_kind), 32'(rsp_ch.found_kind));
        compare_field("found_attribute", 32'(oldest.found_attribute),
                      32'(rsp_ch.found_attribute));
        compare_field("position", 32'(oldest.position), 32'(rsp_ch.position));
        compare_field("entry_total", 32'(oldest.entry_total), 32'(rsp_ch.entry_total));
      end
    end
    rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    logic [1:0]        op;
    logic [KEY_W-1:0]  key;
    logic              kind;
    logic [ATTR_W-1:0] attribute;
    logic [IDX_W-1:0]  index;
    int                pick;
    out_item_t         want;
    failures = 0;
    held_count = 0;
    n_transfers = 0;
    n_placed = 0;
    n_refused = 0;
    n_find_hit = 0;
    n_find_miss = 0;
    n_read_in = 0;
    n_read_out = 0;
    n_unused = 0;
    idle_pct = 0;
    stall_pct = 0;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.op <= OP_INSERT;
    req_ch.key <= '0;
    req_ch.kind <= 1'b0;
    req_ch.attribute <= '0;
    req_ch.index <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (OPENING_STEPS[r]) begin
      send_request(OPENING_STEPS[r].op, OPENING_STEPS[r].key, OPENING_STEPS[r].kind,
                   OPENING_STEPS[r].attribute, OPENING_STEPS[r].index);
      want = apply_request(OPENING_STEPS[r].op, OPENING_STEPS[r].key,
                           OPENING_STEPS[r].kind, OPENING_STEPS[r].attribute,
                           OPENING_STEPS[r].index);
      if (OPENING_STEPS[r].typed) begin
        want = OPENING_STEPS[r].want;
      end
      expected_answers.push_back(want);
    end

    // phases: no idling, sender gaps, receiver stalls, both
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 64 : (phase == 3) ? 21 : 0;
      stall_pct = (phase == 2) ? 64 : (phase == 3) ? 21 : 0;
      repeat (RANDOM_PER_PHASE) begin
        key = KEY_W'($urandom);
        kind = 1'($urandom);
        attribute = ATTR_W'($urandom);
        index = IDX_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 15) begin
          op = OP_INSERT;
        end else if (pick < 50) begin
          op = OP_FIND;
          if (held_count > 0) begin
            key = held[$urandom_range(held_count - 1)].key;
          end
        end else if (pick < 65) begin
          op = OP_FIND;
        end else if (pick < 95) begin
          op = OP_READ;
        end else begin
          op = OP_UNUSED;
        end
        send_request(op, key, kind, attribute, index);
        expected_answers.push_back(apply_request(op, key, kind, attribute, index));
      end
    end
    req_ch.valid <= 1'b0;
    stall_pct = 0;

    while (expected_answers.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d transfers; inserts %0d placed, %0d refused on a full table",
             n_transfers, n_placed, n_refused);
    $display("run: finds %0d hit, %0d missed; reads %0d held, %0d past count; unused op %0d",
             n_find_hit, n_find_miss, n_read_in, n_read_out, n_unused);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
